// File: sv/pslh_pkg.sv
// Package for the power-line serial link handshake block.
// Holds link byte codes, phase enums, item and result structs and the code tables.
// No dependencies.
package pslh_pkg;

   // command codes of one input beat
   localparam logic [1:0] CMD_SEND = 2'd0;
   localparam logic [1:0] CMD_RX   = 2'd1;
   localparam logic [1:0] CMD_SLOT = 2'd2;

   // link bytes
   localparam logic [7:0] BYTE_STX         = 8'h02;
   localparam logic [7:0] BYTE_CMD_CODE    = 8'h63;
   localparam logic [7:0] BYTE_ECHO_START  = 8'h58;
   localparam logic [7:0] BYTE_ASYNC_START = 8'h78;
   localparam logic [7:0] BYTE_ACK         = 8'h06;
   localparam logic [7:0] BYTE_NAK         = 8'h15;
   localparam logic [7:0] BYTE_CR          = 8'h0D;
   localparam logic [7:0] TX_REPEAT_BIAS   = 8'h40;
   localparam logic [7:0] RX_REPEAT_BIAS   = 8'h30;
   localparam logic [7:0] CODE_UNKNOWN     = 8'hFF;
   localparam logic [7:0] LETTER_A         = 8'h41;

   typedef enum logic [3:0] {
      TXP_IDLE     = 4'd0,
      TXP_PREAMBLE = 4'd1,
      TXP_ACKWAIT  = 4'd2,
      TXP_CR       = 4'd3,
      TXP_CMDCODE  = 4'd4,
      TXP_HOUSE    = 4'd5,
      TXP_UNIT     = 4'd6,
      TXP_FUNC     = 4'd7,
      TXP_REPEAT   = 4'd8,
      TXP_ECHO     = 4'd9
   } tx_phase_type;

   typedef enum logic [3:0] {
      RXP_IDLE    = 4'd0,
      RXP_HOUSE1  = 4'd2,
      RXP_UNIT    = 4'd3,
      RXP_REPEAT1 = 4'd4,
      RXP_START2  = 4'd5,
      RXP_HOUSE2  = 4'd6,
      RXP_FUNC    = 4'd7,
      RXP_REPEAT2 = 4'd8
   } rx_phase_type;

   typedef enum logic [1:0] {
      EV_NONE  = 2'd0,
      EV_ECHO  = 2'd1,
      EV_ASYNC = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] rx_byte;
      logic [7:0] house_letter;
      logic [7:0] unit_number;
      logic [7:0] function_index;
      logic [7:0] repeat_count;
   } item_type;

   typedef struct packed {
      logic           tx_valid;
      logic [7:0]     tx_byte;
      event_kind_type event_kind;
      logic [7:0]     house;
      logic [7:0]     unit;
      logic [7:0]     function_res;
      logic [7:0]     repeat_res;
      logic           busy_res;
   } result_type;

   // engine status seen by the top level checks
   typedef struct packed {
      logic         tx_busy;
      logic         rx_busy;
      tx_phase_type tx_phase;
   } status_type;

   localparam logic [7:0] HOUSE_CODES [16] = '{
      8'h46, 8'h4E, 8'h42, 8'h4A, 8'h41, 8'h49, 8'h45, 8'h4D,
      8'h47, 8'h4F, 8'h43, 8'h4B, 8'h40, 8'h48, 8'h44, 8'h4C
   };
   localparam logic [7:0] UNIT_CODES [16] = '{
      8'h4C, 8'h5C, 8'h44, 8'h54, 8'h42, 8'h52, 8'h4A, 8'h5A,
      8'h4E, 8'h5E, 8'h46, 8'h56, 8'h40, 8'h50, 8'h48, 8'h58
   };
   localparam logic [7:0] FUNC_CODES [15] = '{
      8'h41, 8'h43, 8'h45, 8'h47, 8'h49, 8'h4B, 8'h4D, 8'h4F,
      8'h51, 8'h57, 8'h55, 8'h59, 8'h5B, 8'h5D, 8'h5F
   };

   // house letter 'A'..'P' to line code
   function automatic logic [7:0] house_encode(input logic [7:0] letter);
      logic [7:0] off;
      off = letter - LETTER_A;
      if (off < 8'd16) begin
         return HOUSE_CODES[off[3:0]];
      end
      return CODE_UNKNOWN;
   endfunction

   // unit 1..16 to line code
   function automatic logic [7:0] unit_encode(input logic [7:0] unit);
      logic [7:0] off;
      off = unit - 8'd1;
      if (off < 8'd16) begin
         return UNIT_CODES[off[3:0]];
      end
      return CODE_UNKNOWN;
   endfunction

   // function index 0..14 to line code
   function automatic logic [7:0] func_encode(input logic [7:0] func);
      if (func < 8'd15) begin
         return FUNC_CODES[func[3:0]];
      end
      return CODE_UNKNOWN;
   endfunction

   // line code to house letter, unknown when absent
   function automatic logic [7:0] house_decode(input logic [7:0] code);
      logic [7:0] res;
      res = CODE_UNKNOWN;
      for (int i = 15; i >= 0; i--) begin
         if (HOUSE_CODES[i] == code) begin
            res = LETTER_A + 8'(i);
         end
      end
      return res;
   endfunction

   // line code to unit number, unknown when absent
   function automatic logic [7:0] unit_decode(input logic [7:0] code);
      logic [7:0] res;
      res = CODE_UNKNOWN;
      for (int i = 15; i >= 0; i--) begin
         if (UNIT_CODES[i] == code) begin
            res = 8'(i + 1);
         end
      end
      return res;
   endfunction

   // line code to function index, unknown when absent
   function automatic logic [7:0] func_decode(input logic [7:0] code);
      logic [7:0] res;
      res = CODE_UNKNOWN;
      for (int i = 14; i >= 0; i--) begin
         if (FUNC_CODES[i] == code) begin
            res = 8'(i);
         end
      end
      return res;
   endfunction

endpackage

// File: sv/pslh_engine.sv
// Link state engine: transmit and receive phases, records and per-beat result.
// Depends on pslh_pkg for tables, phase enums and the item/result structs.
module pslh_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  pslh_pkg::item_type  item,
   output pslh_pkg::result_type result,
   output pslh_pkg::status_type status
);

   pslh_pkg::tx_phase_type tx_phase_ff, tx_phase_in;
   pslh_pkg::rx_phase_type rx_phase_ff, rx_phase_in;
   logic       tx_busy_ff, tx_busy_in;
   logic       rx_busy_ff, rx_busy_in;
   logic       echo_ff, echo_in;
   logic       slot_en_ff, slot_en_in;
   logic [7:0] tx_house_ff, tx_house_in;
   logic [7:0] tx_unit_ff, tx_unit_in;
   logic [7:0] tx_func_ff, tx_func_in;
   logic [7:0] tx_rep_ff, tx_rep_in;
   logic [7:0] rx_house_ff, rx_house_in;
   logic [7:0] rx_unit_ff, rx_unit_in;
   logic [7:0] rx_func_ff, rx_func_in;

   logic       link_busy;
   logic       hs_cr, hs_ack, hs_nak, hs_any;
   logic       rx_deframe;
   logic [7:0] rx_b;

   // classify the received byte against the handshake
   assign rx_b       = item.rx_byte;
   assign link_busy  = tx_busy_ff | rx_busy_ff;
   assign hs_cr      = tx_busy_ff && (rx_b == pslh_pkg::BYTE_CR)
                       && (tx_phase_ff == pslh_pkg::TXP_CR);
   assign hs_ack     = tx_busy_ff && (rx_b == pslh_pkg::BYTE_ACK)
                       && (tx_phase_ff == pslh_pkg::TXP_ACKWAIT);
   assign hs_nak     = tx_busy_ff && (rx_b == pslh_pkg::BYTE_NAK)
                       && (tx_phase_ff == pslh_pkg::TXP_ACKWAIT);
   assign hs_any     = hs_cr | hs_ack | hs_nak;
   assign rx_deframe = (item.command == pslh_pkg::CMD_RX) && !hs_any
                       && (rx_b != pslh_pkg::BYTE_CR);

   assign status.tx_busy  = tx_busy_ff;
   assign status.rx_busy  = rx_busy_ff;
   assign status.tx_phase = tx_phase_ff;

   // next state
   always_comb begin
      tx_phase_in = tx_phase_ff;
      rx_phase_in = rx_phase_ff;
      tx_busy_in  = tx_busy_ff;
      rx_busy_in  = rx_busy_ff;
      echo_in     = echo_ff;
      slot_en_in  = slot_en_ff;
      tx_house_in = tx_house_ff;
      tx_unit_in  = tx_unit_ff;
      tx_func_in  = tx_func_ff;
      tx_rep_in   = tx_rep_ff;
      rx_house_in = rx_house_ff;
      rx_unit_in  = rx_unit_ff;
      rx_func_in  = rx_func_ff;
      case (item.command)
         pslh_pkg::CMD_SEND: begin
            if (!link_busy) begin
               tx_house_in = pslh_pkg::house_encode(item.house_letter);
               tx_unit_in  = pslh_pkg::unit_encode(item.unit_number);
               tx_func_in  = pslh_pkg::func_encode(item.function_index);
               tx_rep_in   = item.repeat_count + pslh_pkg::TX_REPEAT_BIAS;
               tx_busy_in  = 1'b1;
               tx_phase_in = pslh_pkg::TXP_PREAMBLE;
               slot_en_in  = 1'b1;
            end
         end
         pslh_pkg::CMD_RX: begin
            if (hs_cr) begin
               tx_phase_in = pslh_pkg::TXP_CMDCODE;
               slot_en_in  = 1'b1;
            end else if (hs_ack) begin
               tx_phase_in = pslh_pkg::TXP_CR;
            end else if (hs_nak) begin
               tx_phase_in = pslh_pkg::TXP_PREAMBLE;
               slot_en_in  = 1'b1;
            end else if (rx_deframe) begin
               unique case (rx_phase_ff)
                  pslh_pkg::RXP_IDLE: begin
                     if (rx_b == pslh_pkg::BYTE_ECHO_START) begin
                        echo_in     = 1'b1;
                        rx_phase_in = pslh_pkg::RXP_HOUSE1;
                     end else if (rx_b == pslh_pkg::BYTE_ASYNC_START) begin
                        rx_busy_in  = 1'b1;
                        echo_in     = 1'b0;
                        rx_phase_in = pslh_pkg::RXP_HOUSE1;
                     end
                  end
                  pslh_pkg::RXP_HOUSE1: begin
                     rx_house_in = pslh_pkg::house_decode(rx_b);
                     rx_phase_in = pslh_pkg::RXP_UNIT;
                  end
                  pslh_pkg::RXP_UNIT: begin
                     rx_unit_in  = pslh_pkg::unit_decode(rx_b);
                     rx_phase_in = pslh_pkg::RXP_REPEAT1;
                  end
                  pslh_pkg::RXP_REPEAT1: rx_phase_in = pslh_pkg::RXP_START2;
                  pslh_pkg::RXP_START2:  rx_phase_in = pslh_pkg::RXP_HOUSE2;
                  pslh_pkg::RXP_HOUSE2:  rx_phase_in = pslh_pkg::RXP_FUNC;
                  pslh_pkg::RXP_FUNC: begin
                     rx_func_in  = pslh_pkg::func_decode(rx_b);
                     rx_phase_in = pslh_pkg::RXP_REPEAT2;
                  end
                  pslh_pkg::RXP_REPEAT2: begin
                     if (echo_ff) begin
                        tx_busy_in = 1'b0;
                     end else begin
                        rx_busy_in = 1'b0;
                     end
                     rx_phase_in = pslh_pkg::RXP_IDLE;
                  end
                  default: rx_phase_in = rx_phase_ff;
               endcase
            end
         end
         pslh_pkg::CMD_SLOT: begin
            if (slot_en_ff) begin
               unique case (tx_phase_ff)
                  pslh_pkg::TXP_PREAMBLE: begin
                     tx_phase_in = pslh_pkg::TXP_ACKWAIT;
                     slot_en_in  = 1'b0;
                  end
                  pslh_pkg::TXP_CMDCODE: tx_phase_in = pslh_pkg::TXP_HOUSE;
                  pslh_pkg::TXP_HOUSE:   tx_phase_in = pslh_pkg::TXP_UNIT;
                  pslh_pkg::TXP_UNIT:    tx_phase_in = pslh_pkg::TXP_FUNC;
                  pslh_pkg::TXP_FUNC:    tx_phase_in = pslh_pkg::TXP_REPEAT;
                  pslh_pkg::TXP_REPEAT: begin
                     tx_phase_in = pslh_pkg::TXP_ECHO;
                     slot_en_in  = 1'b0;
                  end
                  default: tx_phase_in = tx_phase_ff;
               endcase
            end
         end
         default: tx_phase_in = tx_phase_ff;
      endcase
   end

   // result of the current beat
   always_comb begin
      result = '0;
      case (item.command)
         pslh_pkg::CMD_SEND: begin
            result.busy_res = link_busy;
         end
         pslh_pkg::CMD_RX: begin
            if (rx_deframe && (rx_phase_ff == pslh_pkg::RXP_REPEAT2)) begin
               result.event_kind   = echo_ff ? pslh_pkg::EV_ECHO : pslh_pkg::EV_ASYNC;
               result.house        = rx_house_ff;
               result.unit         = rx_unit_ff;
               result.function_res = rx_func_ff;
               result.repeat_res   = rx_b - pslh_pkg::RX_REPEAT_BIAS;
            end
         end
         pslh_pkg::CMD_SLOT: begin
            if (slot_en_ff) begin
               unique case (tx_phase_ff)
                  pslh_pkg::TXP_PREAMBLE: begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = pslh_pkg::BYTE_STX;
                  end
                  pslh_pkg::TXP_CMDCODE: begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = pslh_pkg::BYTE_CMD_CODE;
                  end
                  pslh_pkg::TXP_HOUSE: begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = tx_house_ff;
                  end
                  pslh_pkg::TXP_UNIT: begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = tx_unit_ff;
                  end
                  pslh_pkg::TXP_FUNC: begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = tx_func_ff;
                  end
                  pslh_pkg::TXP_REPEAT: begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = tx_rep_ff;
                  end
                  default: result.tx_valid = 1'b0;
               endcase
            end
         end
         default: result.busy_res = 1'b0;
      endcase
   end

   // advance state on each processed beat
   always_ff @(posedge clock) begin
      if (reset) begin
         tx_phase_ff <= pslh_pkg::TXP_IDLE;
         rx_phase_ff <= pslh_pkg::RXP_IDLE;
         tx_busy_ff  <= 1'b0;
         rx_busy_ff  <= 1'b0;
         echo_ff     <= 1'b0;
         slot_en_ff  <= 1'b0;
         tx_house_ff <= '0;
         tx_unit_ff  <= '0;
         tx_func_ff  <= '0;
         tx_rep_ff   <= '0;
         rx_house_ff <= '0;
         rx_unit_ff  <= '0;
         rx_func_ff  <= '0;
      end else if (step) begin
         tx_phase_ff <= tx_phase_in;
         rx_phase_ff <= rx_phase_in;
         tx_busy_ff  <= tx_busy_in;
         rx_busy_ff  <= rx_busy_in;
         echo_ff     <= echo_in;
         slot_en_ff  <= slot_en_in;
         tx_house_ff <= tx_house_in;
         tx_unit_ff  <= tx_unit_in;
         tx_func_ff  <= tx_func_in;
         tx_rep_ff   <= tx_rep_in;
         rx_house_ff <= rx_house_in;
         rx_unit_ff  <= rx_unit_in;
         rx_func_ff  <= rx_func_in;
      end
   end

endmodule

// File: sv/powerline_serial_link_handshake.sv
// Power-line serial link handshake, host side: one result beat per request beat.
// A request is held in the input register, then its result in the result register.
// Throughput: one beat per cycle without rsp_stall; the link state engine updates once per beat.
// Reset: synchronous, active high; clears both stages and returns the link to idle.
// Depends on pslh_pkg and pslh_engine.
module powerline_serial_link_handshake (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_rx_byte,
   input  logic [7:0] req_house_letter,
   input  logic [7:0] req_unit_number,
   input  logic [7:0] req_function_index,
   input  logic [7:0] req_repeat_count,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tx_valid,
   output logic [7:0] rsp_tx_byte,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_house,
   output logic [7:0] rsp_unit,
   output logic [7:0] rsp_function_res,
   output logic [7:0] rsp_repeat_res,
   output logic       rsp_busy_res
);

   logic                  in_valid_ff, in_valid_in;
   pslh_pkg::item_type    in_item_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   pslh_pkg::result_type  rsp_ff;
   pslh_pkg::result_type  step_result;
   pslh_pkg::status_type  status;
   logic                  advance;
   logic                  accept;

   // move the held beat forward when the result register is free or draining
   assign advance     = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = in_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign in_valid_in = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && rsp_stall);

   pslh_engine u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (step_result),
      .status (status)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (accept) begin
         in_item_ff.command        <= req_command;
         in_item_ff.rx_byte        <= req_rx_byte;
         in_item_ff.house_letter   <= req_house_letter;
         in_item_ff.unit_number    <= req_unit_number;
         in_item_ff.function_index <= req_function_index;
         in_item_ff.repeat_count   <= req_repeat_count;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tx_valid     = rsp_ff.tx_valid;
   assign rsp_tx_byte      = rsp_ff.tx_byte;
   assign rsp_event_kind   = rsp_ff.event_kind;
   assign rsp_house        = rsp_ff.house;
   assign rsp_unit         = rsp_ff.unit;
   assign rsp_function_res = rsp_ff.function_res;
   assign rsp_repeat_res   = rsp_ff.repeat_res;
   assign rsp_busy_res     = rsp_ff.busy_res;

`ifndef NO_ASSERTIONS
   // a refused send carries no byte and no event
   a_busy_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_busy_res) |->
         (!rsp_tx_valid && rsp_event_kind == pslh_pkg::EV_NONE))
      else $error("refused send carries byte or event");

   // an idle byte slot carries a zero byte
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tx_valid) |-> (rsp_tx_byte == 8'd0))
      else $error("tx byte set without tx valid");

   // the transmitter leaves idle only together with the busy flag
   a_idle_not_busy: assert property (@(posedge clock) disable iff (reset)
      (status.tx_phase == pslh_pkg::TXP_IDLE) |-> !status.tx_busy)
      else $error("transmitter busy while idle");

   // a held beat stays held until it moves to the result register
   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("held beat lost");
`endif

endmodule
